[src/sbfr_pkg.sv]
// Package for the start-byte frame receiver.
// Holds the event, phase, status and register codes and the beat, config and result types.
// No dependencies.
package sbfr_pkg;

  // Payload lengths above this act as this length.
  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned COUNT_WIDTH = 8;

  typedef enum logic [1:0] {
    OP_BYTE     = 2'd0,
    OP_TIMEOUT  = 2'd1,
    OP_PORT_ERR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_SUM  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_GOOD      = 3'd0,
    ST_BAD_SUM   = 3'd1,
    ST_NO_DATA   = 3'd2,
    ST_PORT_ERR  = 3'd3,
    ST_LINK_LOST = 3'd4
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    CFG_START_BYTE     = 2'd0,
    CFG_PAYLOAD_LENGTH = 2'd1,
    CFG_TIMEOUT_LIMIT  = 2'd2,
    CFG_SILENCE_LIMIT  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [6:0] payload_length;
    logic [7:0] timeout_limit;
    logic [7:0] silence_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } beat_t;

  typedef struct packed {
    logic [0:0] kind;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic [2:0] frame_status;
  } res_t;

endpackage

[src/sbfr_in_reg.sv]
// Input register of the start-byte frame receiver.
// Captures one event beat and holds it until the frame logic takes it; uses sbfr_pkg.
module sbfr_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    op_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          take_i,
  output logic          valid_o,
  output sbfr_pkg::beat_t beat_o
);

  logic            valid_q, valid_d;
  sbfr_pkg::beat_t beat_q;
  logic            load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q.op      <= op_i;
      beat_q.rx_byte <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

[src/sbfr_core.sv]
// Frame logic of the start-byte frame receiver, uses sbfr_pkg: phase, counters, checksum
// and status. Takes one registered event per cycle if slot_free_i; at most one result.
module sbfr_core #(
  parameter int unsigned CountWidth = sbfr_pkg::COUNT_WIDTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sbfr_pkg::cfg_t cfg_i,
  input  logic           beat_valid_i,
  input  sbfr_pkg::beat_t beat_i,
  input  logic           slot_free_i,
  output logic           take_o,
  output logic           res_valid_o,
  output sbfr_pkg::res_t res_o
);

  localparam int unsigned CmpW = (CountWidth > 8) ? CountWidth : 8;

  sbfr_pkg::phase_e       phase_q, phase_d;
  logic [6:0]             count_q, count_d;
  logic [7:0]             sum_q, sum_d;
  logic [CountWidth-1:0]  to_run_q, to_run_d;
  logic [CountWidth-1:0]  sil_run_q, sil_run_d;
  logic                   retry_q, retry_d;

  logic [7:0] eff_len;
  logic [7:0] count_inc;
  logic       to_trip;
  logic       sil_trip;

  assign take_o = beat_valid_i && slot_free_i;

  // Effective payload length, clamped to the largest frame.
  assign eff_len = ({1'b0, cfg_i.payload_length} > 8'(sbfr_pkg::MAX_PAYLOAD))
                 ? 8'(sbfr_pkg::MAX_PAYLOAD) : {1'b0, cfg_i.payload_length};
  assign count_inc = {1'b0, count_q} + 8'd1;

  assign to_trip  = CmpW'(to_run_q) >= CmpW'(cfg_i.timeout_limit);
  assign sil_trip = CmpW'(sil_run_q) >= CmpW'(cfg_i.silence_limit);

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    sum_d       = sum_q;
    to_run_d    = to_run_q;
    sil_run_d   = sil_run_q;
    retry_d     = retry_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (take_o) begin
      case (sbfr_pkg::op_e'(beat_i.op))
        sbfr_pkg::OP_BYTE: begin
          to_run_d = '0;
          retry_d  = 1'b0;
          case (phase_q)
            sbfr_pkg::PH_DATA: begin
              res_valid_o        = 1'b1;
              res_o.kind         = sbfr_pkg::KIND_PAYLOAD;
              res_o.payload_byte = beat_i.rx_byte;
              res_o.byte_index   = count_q[5:0];
              sum_d              = sum_q + beat_i.rx_byte;
              count_d            = count_inc[6:0];
              if (count_inc >= eff_len) begin
                phase_d = sbfr_pkg::PH_SUM;
              end
            end
            sbfr_pkg::PH_SUM: begin
              sil_run_d          = '0;
              res_valid_o        = 1'b1;
              res_o.kind         = sbfr_pkg::KIND_STATUS;
              res_o.frame_status = (beat_i.rx_byte == sum_q) ? sbfr_pkg::ST_GOOD
                                                              : sbfr_pkg::ST_BAD_SUM;
              phase_d            = sbfr_pkg::PH_HUNT;
            end
            default: begin
              if (beat_i.rx_byte == cfg_i.start_byte) begin
                count_d = '0;
                sum_d   = '0;
                phase_d = (eff_len == 8'd0) ? sbfr_pkg::PH_SUM : sbfr_pkg::PH_DATA;
              end
            end
          endcase
        end
        sbfr_pkg::OP_TIMEOUT: begin
          if (to_trip) begin
            to_run_d           = '0;
            res_valid_o        = 1'b1;
            res_o.kind         = sbfr_pkg::KIND_STATUS;
            res_o.frame_status = sbfr_pkg::ST_PORT_ERR;
            phase_d            = sbfr_pkg::PH_HUNT;
            retry_d            = 1'b0;
          end else begin
            to_run_d = (to_run_q != '1) ? to_run_q + 1'b1 : to_run_q;
            if (phase_q != sbfr_pkg::PH_HUNT && !retry_q) begin
              // First timeout inside a frame is only retried.
              retry_d = 1'b1;
            end else begin
              res_valid_o = 1'b1;
              res_o.kind  = sbfr_pkg::KIND_STATUS;
              phase_d     = sbfr_pkg::PH_HUNT;
              retry_d     = 1'b0;
              if (sil_trip) begin
                sil_run_d          = '0;
                res_o.frame_status = sbfr_pkg::ST_LINK_LOST;
              end else begin
                sil_run_d          = (sil_run_q != '1) ? sil_run_q + 1'b1 : sil_run_q;
                res_o.frame_status = sbfr_pkg::ST_NO_DATA;
              end
            end
          end
        end
        sbfr_pkg::OP_PORT_ERR: begin
          to_run_d           = '0;
          res_valid_o        = 1'b1;
          res_o.kind         = sbfr_pkg::KIND_STATUS;
          res_o.frame_status = sbfr_pkg::ST_PORT_ERR;
          phase_d            = sbfr_pkg::PH_HUNT;
          retry_d            = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= sbfr_pkg::PH_HUNT;
      count_q   <= '0;
      sum_q     <= '0;
      to_run_q  <= '0;
      sil_run_q <= '0;
      retry_q   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      to_run_q  <= to_run_d;
      sil_run_q <= sil_run_d;
      retry_q   <= retry_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A pending retry only exists inside a frame.
  a_retry_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retry_q |-> phase_q != sbfr_pkg::PH_HUNT)
    else $error("retry pending while hunting");

  // Every status result ends the frame.
  a_status_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == sbfr_pkg::KIND_STATUS |=>
      phase_q == sbfr_pkg::PH_HUNT && !retry_q)
    else $error("status result did not return to hunting");

  // A port error event clears the timeout run.
  a_port_err_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && beat_i.op == sbfr_pkg::OP_PORT_ERR |=> to_run_q == '0)
    else $error("port error left timeout run set");

  // Payload bytes only come out while inside the data phase.
  a_payload_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == sbfr_pkg::KIND_PAYLOAD |-> phase_q == sbfr_pkg::PH_DATA)
    else $error("payload beat outside data phase");
`endif

endmodule

[src/sbfr_out_reg.sv]
// Result register of the start-byte frame receiver.
// Holds one result beat until the consumer takes it; uses sbfr_pkg.
module sbfr_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  sbfr_pkg::res_t res_i,
  output logic           slot_free_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output sbfr_pkg::res_t res_o
);

  logic           valid_q, valid_d;
  sbfr_pkg::res_t res_q;

  assign slot_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[src/start_byte_frame_receiver.sv]
// Start-byte frame receiver: hunts for a start byte, passes payload bytes, checks the sum.
// An accepted event beat goes through the input register, then the frame logic into the
// result register; one event beat is taken every cycle while the result register has room.
// Reset (rst_ni low, asynchronous) empties both registers, returns to hunting with all
// counters cleared, and sets the registers to start 0, length 1, limits 3 and 3.
// Uses sbfr_pkg, sbfr_in_reg, sbfr_core and sbfr_out_reg.
module start_byte_frame_receiver #(
  parameter int unsigned CountWidth = sbfr_pkg::COUNT_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] payload_byte_o,
  output logic [5:0] byte_index_o,
  output logic [2:0] frame_status_o
);

  sbfr_pkg::cfg_t  cfg_q, cfg_d;
  sbfr_pkg::beat_t beat;
  sbfr_pkg::res_t  core_res;
  sbfr_pkg::res_t  out_res;
  logic            beat_valid;
  logic            take;
  logic            core_res_valid;
  logic            slot_free;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (sbfr_pkg::cfg_idx_e'(cfg_index_i))
        sbfr_pkg::CFG_START_BYTE:     cfg_d.start_byte     = cfg_wdata_i;
        sbfr_pkg::CFG_PAYLOAD_LENGTH: cfg_d.payload_length = cfg_wdata_i[6:0];
        sbfr_pkg::CFG_TIMEOUT_LIMIT:  cfg_d.timeout_limit  = cfg_wdata_i;
        sbfr_pkg::CFG_SILENCE_LIMIT:  cfg_d.silence_limit  = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte     <= 8'd0;
      cfg_q.payload_length <= 7'd1;
      cfg_q.timeout_limit  <= 8'd3;
      cfg_q.silence_limit  <= 8'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sbfr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .rx_byte_i  (rx_byte_i),
    .take_i     (take),
    .valid_o    (beat_valid),
    .beat_o     (beat)
  );

  sbfr_core #(
    .CountWidth (CountWidth)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .beat_valid_i (beat_valid),
    .beat_i       (beat),
    .slot_free_i  (slot_free),
    .take_o       (take),
    .res_valid_o  (core_res_valid),
    .res_o        (core_res)
  );

  sbfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (core_res_valid),
    .res_i       (core_res),
    .slot_free_o (slot_free),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign kind_o         = out_res.kind;
  assign payload_byte_o = out_res.payload_byte;
  assign byte_index_o   = out_res.byte_index;
  assign frame_status_o = out_res.frame_status;

endmodule
